>>> rtl/sbr_pkg.sv
// Shared types and constants for the separable bicubic resample unit.
`timescale 1ns / 1ps
`default_nettype none
package sbr_pkg;
    localparam int POS_W    = 11;
    localparam int TAP_W    = 5;
    localparam int WGT_W    = 24;
    localparam int CNT_IN_W = 6;
    localparam int CNT_W    = 8;   // holds the tap count, saturated to MAX_TAPS
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int PROD_W   = WGT_W + CH_W + 1;
    localparam int ACC_W    = 48;
    localparam int CH_MAX   = 255;

    typedef enum logic [1:0] {
        OP_TAPS   = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_COMP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [POS_W-1:0]         pos;
        logic [TAP_W-1:0]         tap;
        logic signed [WGT_W-1:0]  weight;
        logic [POS_W-1:0]         first;
        logic [CNT_W-1:0]         cnt;
        logic [PIX_W-1:0]         pix;   // {red, green, blue}
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_META,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

>>> rtl/sbr_front.sv
// Front end: accepts items, drops out-of-range ones, queues commands.
`timescale 1ns / 1ps
`default_nettype none
module sbr_front #(
    parameter int MAX_SOURCE = 2048,
    parameter int MAX_OUTPUT = 512,
    parameter int MAX_TAPS   = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [1:0]                     i_mode,
    input  wire  [sbr_pkg::POS_W-1:0]      i_position,
    input  wire  [sbr_pkg::TAP_W-1:0]      i_tap_index,
    input  wire  signed [sbr_pkg::WGT_W-1:0] i_weight,
    input  wire  [sbr_pkg::POS_W-1:0]      i_first_source,
    input  wire  [sbr_pkg::CNT_IN_W-1:0]   i_tap_count,
    input  wire  [sbr_pkg::CH_W-1:0]       i_blue_in,
    input  wire  [sbr_pkg::CH_W-1:0]       i_green_in,
    input  wire  [sbr_pkg::CH_W-1:0]       i_red_in,
    output sbr_pkg::t_cmd                  o_cmd,
    output logic                           o_cmd_valid,
    input  wire                            i_pop
);
    import sbr_pkg::*;

    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd w_cmd;
    logic w_keep, w_push;

    always_comb begin
        w_cmd.op     = t_op'(i_mode);
        w_cmd.pos    = i_position;
        w_cmd.tap    = i_tap_index;
        w_cmd.weight = i_weight;
        w_cmd.first  = i_first_source;
        if (32'(i_tap_count) > MAX_TAPS) begin
            w_cmd.cnt = CNT_W'(MAX_TAPS);
        end else begin
            w_cmd.cnt = CNT_W'(i_tap_count);
        end
        w_cmd.pix = {i_red_in, i_green_in, i_blue_in};
        case (t_op'(i_mode))
            OP_TAPS:   w_keep = 32'(i_position) < MAX_OUTPUT;
            OP_WEIGHT: w_keep = (32'(i_position) < MAX_OUTPUT)
                                && (32'(i_tap_index) < MAX_TAPS);
            OP_PIXEL:  w_keep = 32'(i_position) < MAX_SOURCE;
            OP_COMP:   w_keep = 32'(i_position) < MAX_OUTPUT;
            default:   w_keep = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall && w_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end
endmodule
`default_nettype wire

>>> rtl/sbr_back.sv
// Back end: table and line memories, tap walker with multiply-accumulate.
`timescale 1ns / 1ps
`default_nettype none
module sbr_back #(
    parameter int MAX_SOURCE    = 2048,
    parameter int MAX_OUTPUT    = 512,
    parameter int MAX_TAPS      = 32,
    parameter int FRACTION_BITS = 22
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  sbr_pkg::t_cmd              i_cmd,
    input  wire                        i_cmd_valid,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [sbr_pkg::POS_W-1:0]  o_result_position,
    output logic [sbr_pkg::CH_W-1:0]   o_blue_out,
    output logic [sbr_pkg::CH_W-1:0]   o_green_out,
    output logic [sbr_pkg::CH_W-1:0]   o_red_out
);
    import sbr_pkg::*;

    localparam int OAW  = (MAX_OUTPUT > 1) ? $clog2(MAX_OUTPUT) : 1;
    localparam int LAW  = $clog2(MAX_SOURCE);
    localparam int WAW  = $clog2(MAX_OUTPUT * MAX_TAPS);
    localparam int SRCW = LAW + 2;
    localparam int KW   = CNT_W;
    localparam int META_W = POS_W + CNT_W;

    logic [META_W-1:0]       meta_mem [MAX_OUTPUT];
    logic signed [WGT_W-1:0] wgt_mem  [MAX_OUTPUT * MAX_TAPS];
    logic [PIX_W-1:0]        line_mem [MAX_SOURCE];

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [META_W-1:0]       r_meta_q;
    logic signed [WGT_W-1:0] r_wgt_q;
    logic [PIX_W-1:0]        r_pix_q;
    logic [POS_W-1:0]        r_origin;
    logic [CNT_W-1:0]        r_total;
    logic [KW-1:0]           r_k;
    logic                    r_skip;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc  [3];
    logic                    r_out_valid;
    logic [POS_W-1:0]        r_res_pos;
    logic [CH_W-1:0]         r_res [3];

    logic [OAW-1:0]  w_meta_addr;
    logic [WAW-1:0]  w_wgt_addr;
    logic [SRCW-1:0] w_src;
    logic            w_src_ok;
    logic            w_out_free;
    logic            w_load_out;
    logic            w_meta_we, w_wgt_we, w_line_we;

    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] q;
        q = a >>> FRACTION_BITS;
        if (a < 0) begin
            return '0;
        end else if (q > ACC_W'(CH_MAX)) begin
            return CH_W'(CH_MAX);
        end else begin
            return q[CH_W-1:0];
        end
    endfunction

    assign w_meta_addr = (r_state == ST_IDLE) ? OAW'(32'(i_cmd.pos)) : OAW'(32'(r_cmd.pos));
    assign w_wgt_addr  = WAW'(32'(r_cmd.pos) * MAX_TAPS + 32'(r_k));
    assign w_src       = SRCW'(r_origin) + SRCW'(r_k);
    assign w_src_ok    = 32'(w_src) < MAX_SOURCE;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_pop     = (r_state == ST_IDLE) && i_cmd_valid;
    assign w_meta_we = o_pop && (i_cmd.op == OP_TAPS);
    assign w_wgt_we  = o_pop && (i_cmd.op == OP_WEIGHT);
    assign w_line_we = o_pop && (i_cmd.op == OP_PIXEL);

    always_comb begin
        n_state    = r_state;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && (i_cmd.op == OP_COMP)) begin
                    n_state = ST_META;
                end
            end
            ST_META: n_state = ST_READ;
            ST_READ: begin
                if (r_k >= r_total) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_READ;
            ST_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            meta_mem[OAW'(32'(i_cmd.pos))] <= {i_cmd.first, i_cmd.cnt};
        end
        r_meta_q <= meta_mem[w_meta_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wgt_we) begin
            wgt_mem[WAW'(32'(i_cmd.pos) * MAX_TAPS + 32'(i_cmd.tap))] <= i_cmd.weight;
        end
        r_wgt_q <= wgt_mem[w_wgt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_line_we) begin
            line_mem[LAW'(32'(i_cmd.pos))] <= i_cmd.pix;
        end
        r_pix_q <= line_mem[w_src[LAW-1:0]];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        case (r_state)
            ST_META: begin
                r_origin <= r_meta_q[META_W-1:CNT_W];
                r_total  <= r_meta_q[CNT_W-1:0];
                r_k      <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= ACC_W'(64'sd1 <<< (FRACTION_BITS - 1));
                end
            end
            ST_READ: r_skip <= !w_src_ok;
            ST_MUL: begin
                for (int c = 0; c < 3; c++) begin
                    if (r_skip) begin
                        r_prod[c] <= '0;
                    end else begin
                        r_prod[c] <= r_wgt_q * $signed({1'b0, r_pix_q[c*CH_W +: CH_W]});
                    end
                end
            end
            ST_ACC: begin
                r_k <= r_k + KW'(1);
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
                end
            end
            default: ;
        endcase
        if (w_load_out) begin
            r_res_pos <= r_cmd.pos;
            for (int c = 0; c < 3; c++) begin
                r_res[c] <= clamp_ch(r_acc[c]);
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_position = r_res_pos;
    assign o_blue_out        = r_res[0];
    assign o_green_out       = r_res[1];
    assign o_red_out         = r_res[2];
endmodule
`default_nettype wire

>>> rtl/separable_bicubic_resample_axis_unit.sv
// Top level of the one-axis separable bicubic resample unit.
// Flow: a load item passes through the command queue and is then written to
//   its table; a compute item is walked tap by tap (one memory read, multiply
//   and accumulate step per tap in the back end) before its result is registered.
// Throughput: one load per cycle unless stalled; computes walked one at a time.
// Reset: synchronous active low clears queue, sequencer and output valid;
//   the memories are not cleared and hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module separable_bicubic_resample_axis_unit #(
    parameter int MAX_SOURCE    = 2048,
    parameter int MAX_OUTPUT    = 512,
    parameter int MAX_TAPS      = 32,
    parameter int FRACTION_BITS = 22
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [1:0]                       i_mode,
    input  wire  [sbr_pkg::POS_W-1:0]        i_position,
    input  wire  [sbr_pkg::TAP_W-1:0]        i_tap_index,
    input  wire  signed [sbr_pkg::WGT_W-1:0] i_weight,
    input  wire  [sbr_pkg::POS_W-1:0]        i_first_source,
    input  wire  [sbr_pkg::CNT_IN_W-1:0]     i_tap_count,
    input  wire  [sbr_pkg::CH_W-1:0]         i_blue_in,
    input  wire  [sbr_pkg::CH_W-1:0]         i_green_in,
    input  wire  [sbr_pkg::CH_W-1:0]         i_red_in,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [sbr_pkg::POS_W-1:0]        o_result_position,
    output logic [sbr_pkg::CH_W-1:0]         o_blue_out,
    output logic [sbr_pkg::CH_W-1:0]         o_green_out,
    output logic [sbr_pkg::CH_W-1:0]         o_red_out
);
    import sbr_pkg::*;

    // command queue between the classifier and the tap walker
    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_pop;

    sbr_front #(
        .MAX_SOURCE (MAX_SOURCE),
        .MAX_OUTPUT (MAX_OUTPUT),
        .MAX_TAPS   (MAX_TAPS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_position     (i_position),
        .i_tap_index    (i_tap_index),
        .i_weight       (i_weight),
        .i_first_source (i_first_source),
        .i_tap_count    (i_tap_count),
        .i_blue_in      (i_blue_in),
        .i_green_in     (i_green_in),
        .i_red_in       (i_red_in),
        .o_cmd          (w_cmd),
        .o_cmd_valid    (w_cmd_valid),
        .i_pop          (w_pop)
    );

    // memories and multiply-accumulate; result held in an output register
    sbr_back #(
        .MAX_SOURCE    (MAX_SOURCE),
        .MAX_OUTPUT    (MAX_OUTPUT),
        .MAX_TAPS      (MAX_TAPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cmd_valid       (w_cmd_valid),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_position (o_result_position),
        .o_blue_out        (o_blue_out),
        .o_green_out       (o_green_out),
        .o_red_out         (o_red_out)
    );
endmodule
`default_nettype wire

>>> rtl/sbr_checker.sv
// Port-level checker for the resample unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [10:0] o_result_position,
    input wire [7:0]  o_blue_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_result_position) && $stable(o_blue_out))
        else $error("stalled result item changed");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");
endmodule

bind separable_bicubic_resample_axis_unit sbr_checker u_sbr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_result_position (o_result_position),
    .o_blue_out        (o_blue_out)
);
`default_nettype wire

>>> verif/separable_bicubic_resample_axis_unit_tb.sv
// Self-checking testbench for the separable bicubic resample unit.
`timescale 1ns / 1ps
`default_nettype none
module separable_bicubic_resample_axis_unit_tb;
    import sbr_pkg::*;

    localparam int N_SRC   = 2048;
    localparam int N_OUT   = 512;
    localparam int N_TAPS  = 32;
    localparam int FRAC    = 22;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
    } t_pixel_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_mode = '0;
    logic [POS_W-1:0] i_position = '0;
    logic [TAP_W-1:0] i_tap_index = '0;
    logic signed [WGT_W-1:0] i_weight = '0;
    logic [POS_W-1:0] i_first_source = '0;
    logic [CNT_IN_W-1:0] i_tap_count = '0;
    logic [CH_W-1:0] i_blue_in = '0, i_green_in = '0, i_red_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [POS_W-1:0] o_result_position;
    logic [CH_W-1:0] o_blue_out, o_green_out, o_red_out;

    separable_bicubic_resample_axis_unit DUT (.*);

    // Shadow copies of the block's tables, plus written flags so that
    // stimulus never reads an entry the hardware holds as garbage.
    logic [PIX_W-1:0]        line_pix [N_SRC];
    bit                      line_ok  [N_SRC];
    logic [POS_W-1:0]        origin_tab [N_OUT];
    int                      count_tab  [N_OUT];
    bit                      meta_ok    [N_OUT];
    logic signed [WGT_W-1:0] weight_tab [N_OUT*N_TAPS];
    bit                      weight_ok  [N_OUT*N_TAPS];

    t_pixel_result pending_pixels[$];
    int  n_errors = 0;
    int  n_sent = 0;
    bit  idle_enable = 1'b1;
    longint cycle_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog on total run time.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] clamp_to_channel(longint acc);
        longint q;
        if (acc < 0) return '0;
        q = acc >>> FRAC;
        return (q > CH_MAX) ? CH_W'(CH_MAX) : CH_W'(q);
    endfunction

    // Predict the effect of one input item; queues a result for computes.
    function automatic void predict_item(logic [1:0] mode, int pos, int tap,
                                         logic signed [WGT_W-1:0] w, int first,
                                         int cnt, logic [PIX_W-1:0] pix);
        longint acc [3];
        int src;
        t_pixel_result r;
        case (t_op'(mode))
            OP_TAPS: begin
                if (pos < N_OUT) begin
                    origin_tab[pos] = first;
                    count_tab[pos]  = (cnt > N_TAPS) ? N_TAPS : cnt;
                    meta_ok[pos]    = 1'b1;
                end
            end
            OP_WEIGHT: begin
                if (pos < N_OUT && tap < N_TAPS) begin
                    weight_tab[pos*N_TAPS+tap] = w;
                    weight_ok[pos*N_TAPS+tap]  = 1'b1;
                end
            end
            OP_PIXEL: begin
                if (pos < N_SRC) begin
                    line_pix[pos] = pix;
                    line_ok[pos]  = 1'b1;
                end
            end
            OP_COMP: begin
                if (pos < N_OUT) begin
                    for (int c = 0; c < 3; c++) acc[c] = longint'(1) << (FRAC - 1);
                    for (int k = 0; k < count_tab[pos]; k++) begin
                        src = origin_tab[pos] + k;
                        if (src >= N_SRC) continue;
                        for (int c = 0; c < 3; c++)
                            acc[c] += longint'(weight_tab[pos*N_TAPS+k]) *
                                      longint'(line_pix[src][c*CH_W +: CH_W]);
                    end
                    r.pos   = POS_W'(pos);
                    r.blue  = clamp_to_channel(acc[0]);
                    r.green = clamp_to_channel(acc[1]);
                    r.red   = clamp_to_channel(acc[2]);
                    pending_pixels.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // A compute is safe only if everything it reads has been written.
    function automatic bit compute_is_safe(int pos);
        int src;
        if (pos >= N_OUT) return 1'b1;
        if (!meta_ok[pos]) return 1'b0;
        for (int k = 0; k < count_tab[pos]; k++) begin
            src = origin_tab[pos] + k;
            if (!weight_ok[pos*N_TAPS+k]) return 1'b0;
            if (src < N_SRC && !line_ok[src]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Send one item; drives at the falling edge, waits for acceptance.
    task automatic send_item(logic [1:0] mode, int pos, int tap = 0,
                             logic signed [WGT_W-1:0] w = '0, int first = 0,
                             int cnt = 0, logic [PIX_W-1:0] pix = '0);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_position     <= POS_W'(pos);
        i_tap_index    <= TAP_W'(tap);
        i_weight       <= w;
        i_first_source <= POS_W'(first);
        i_tap_count    <= CNT_IN_W'(cnt);
        {i_red_in, i_green_in, i_blue_in} <= pix;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(mode, pos, tap, w, first, cnt, pix);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Result checker: sample at rising edge, drive stall at falling edge.
    always @(posedge i_clk) begin
        t_pixel_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result at position %0d", o_result_position);
                n_errors++;
            end else begin
                e = pending_pixels.pop_front();
                if (o_result_position !== e.pos) begin
                    $error("result_position exp %0d got %0d", e.pos, o_result_position);
                    n_errors++;
                end
                if (o_blue_out !== e.blue) begin
                    $error("blue_out exp %0d got %0d", e.blue, o_blue_out);
                    n_errors++;
                end
                if (o_green_out !== e.green) begin
                    $error("green_out exp %0d got %0d", e.green, o_green_out);
                    n_errors++;
                end
                if (o_red_out !== e.red) begin
                    $error("red_out exp %0d got %0d", e.red, o_red_out);
                    n_errors++;
                end
            end
        end
    end

    // Output stall in random bursts while idling is on.
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_enable && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [WGT_W-1:0] rand_weight();
        int v;
        v = $urandom_range(0, 8388608) - 4194304;
        return WGT_W'(v);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        return PIX_W'($urandom);
    endfunction

    // Load a full tap set for one output position, then compute it.
    task automatic run_position(int pos, int first, int cnt, bit random_w);
        int n;
        n = (cnt > N_TAPS) ? N_TAPS : cnt;
        send_item(OP_TAPS, pos, 0, '0, first, cnt);
        for (int k = 0; k < n; k++)
            send_item(OP_WEIGHT, pos, k,
                      random_w ? rand_weight() : WGT_W'((1 << FRAC) / n));
        for (int k = 0; k < n; k++)
            if (first + k < N_SRC && !line_ok[first + k])
                send_item(OP_PIXEL, first + k, 0, '0, 0, 0, rand_pixel());
        send_item(OP_COMP, pos);
    endtask

    task automatic test_directed();
        // Extreme pixels and weights.
        send_item(OP_PIXEL, 0, 0, '0, 0, 0, '1);
        send_item(OP_PIXEL, N_SRC - 1, 0, '0, 0, 0, '0);
        send_item(OP_PIXEL, 1, 0, '0, 0, 0, 24'hAA55F0);
        send_item(OP_TAPS, 0, 0, '0, 0, 2);
        send_item(OP_WEIGHT, 0, 0, 24'sd4194304);
        send_item(OP_WEIGHT, 0, 1, -24'sd4194304);
        send_item(OP_COMP, 0);
        // Zero taps gives the rounding half only.
        send_item(OP_TAPS, N_OUT - 1, 0, '0, N_SRC - 1, 0);
        send_item(OP_COMP, N_OUT - 1);
        // Taps past the end of the line contribute nothing.
        send_item(OP_TAPS, 1, 0, '0, N_SRC - 1, 3);
        send_item(OP_WEIGHT, 1, 0, 24'sd4194304);
        send_item(OP_WEIGHT, 1, 1, 24'sd4194304);
        send_item(OP_WEIGHT, 1, 2, -24'sd4194304);
        send_item(OP_COMP, 1);
        // Ignored loads and computes out of range.
        send_item(OP_TAPS, 2047, 0, '0, 5, 5);
        send_item(OP_WEIGHT, N_OUT, 3, 24'sd5);
        send_item(OP_COMP, 1500);
        // Saturated tap count with random weights, which may clamp to 255 or to 0.
        run_position(2, 0, 63, 1'b1);
        run_position(3, 100, 33, 1'b1);
    endtask

    task automatic test_random(int n_items);
        int pos, stop;
        stop = n_sent + n_items;
        while (n_sent < stop) begin
            case ($urandom_range(0, 9))
                0: begin   // noise: out-of-range loads and computes
                    send_item(OP_TAPS, $urandom_range(N_OUT, 2047), 0, '0,
                              $urandom_range(0, 2047), $urandom_range(0, 63));
                    send_item(OP_COMP, $urandom_range(N_OUT, 2047));
                end
                1: begin   // recompute an already loaded position
                    pos = $urandom_range(0, N_OUT - 1);
                    if (compute_is_safe(pos)) begin
                        send_item(OP_COMP, pos);
                    end
                end
                2: begin   // overwrite a pixel anywhere
                    send_item(OP_PIXEL, $urandom_range(0, 2047), 0, '0, 0, 0, rand_pixel());
                end
                default: begin
                    pos = $urandom_range(0, N_OUT - 1);
                    run_position(pos, ($urandom_range(0, 7) == 0) ?
                                 $urandom_range(N_SRC - 8, N_SRC - 1) :
                                 $urandom_range(0, N_SRC - 1),
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                              : $urandom_range(4, 12),
                                 $urandom_range(0, 3) != 0);
                end
            endcase
        end
    endtask

    task automatic wait_drain();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(1250);
        idle_enable = 1'b0;   // last stretch runs at full rate
        test_random(300);
        i_in_valid <= 1'b0;
        wait_drain();
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
